FILE: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds the transaction payload structs, operation and status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Default width at which numerators and denominators are taken.
  localparam int VALUE_BITS_DEF = 32;

  // Width of the products and of the GCD and shared divide datapaths.
  localparam int PROD_W = 64;

  // Operation codes.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] lhs_num;
    logic [30:0]        lhs_den;
    logic signed [31:0] rhs_num;
    logic [30:0]        rhs_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
    logic               lhs_less;
    logic               operands_equal;
  } out_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_CALC  = 8'b0000_0100,
    S_GCD   = 8'b0000_1000,
    S_DIVN  = 8'b0001_0000,
    S_DIVD  = 8'b0010_0000,
    S_CHECK = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

endpackage

FILE: hw/rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary GCD
// Finds the greatest common divisor of two nonzero 64-bit magnitudes with one
// shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [rau_pkg::PROD_W-1:0]  a_in,
  input  logic [rau_pkg::PROD_W-1:0]  b_in,
  output logic [rau_pkg::PROD_W-1:0]  gcd,
  output logic                        done
);

  localparam int KW = $clog2(rau_pkg::PROD_W);

  logic [rau_pkg::PROD_W-1:0] a_r, b_r, g_r;
  logic [KW-1:0]              k_r;
  logic                       busy_r, done_r;

  // One reduction step per cycle while busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        a_r    <= a_in;
        b_r    <= b_in;
        k_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!a_r[0] && !b_r[0]) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r == b_r) begin
          g_r    <= a_r << k_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (a_r > b_r) begin
          a_r <= (a_r - b_r) >> 1;
        end else begin
          b_r <= (b_r - a_r) >> 1;
        end
      end
    end
  end

  assign gcd  = g_r;
  assign done = done_r;

endmodule

FILE: hw/rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: iterative restoring divider
// Divides a 64-bit magnitude by a nonzero 64-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [rau_pkg::PROD_W-1:0]  dividend,
  input  logic [rau_pkg::PROD_W-1:0]  divisor,
  output logic [rau_pkg::PROD_W-1:0]  quotient,
  output logic                        done
);

  localparam int CW = $clog2(rau_pkg::PROD_W);

  logic [rau_pkg::PROD_W-1:0] rem_r, quo_r, dvs_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, done_r;
  logic [rau_pkg::PROD_W:0]   trial;
  logic [rau_pkg::PROD_W:0]   diff;
  logic                       fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem_r, quo_r[rau_pkg::PROD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[rau_pkg::PROD_W-1:0] : trial[rau_pkg::PROD_W-1:0];
        quo_r <= {quo_r[rau_pkg::PROD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(rau_pkg::PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: hw/rtl/rational_arith_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_top: rational arithmetic with GCD reduction
// Adds, subtracts, multiplies or divides two rationals, reduces the result by
// the binary GCD and flags ordering and equality of the operands.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  rau_pkg::in_t
//   out_     output     out_valid/out_stall rau_pkg::out_t
//
// A transaction passes in order through the accept, multiply and setup
// states, the binary GCD loop, a division of the numerator and then of the
// denominator by the GCD on the shared divider, and the check and hand-off
// states; the GCD loop and the divider take the longest. Zero results and
// zero denominators skip the GCD and division.
// Reset is synchronous and active low. The next input is taken once the
// previous result sits in the output register, even while out_stall holds it
// there; a stalled older result holds the sequencer in its wait state.
// ----------------------------------------------------------------------------
module rational_arith_unit_top #(
  parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rau_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rau_pkg::out_t  out_data
);

  localparam int                   SH   = 32 - VALUE_BITS;
  localparam logic [30:0]          DMSK = 31'((64'(1) << (VALUE_BITS - 1)) - 64'(1));
  localparam logic [rau_pkg::PROD_W-1:0] LIM = rau_pkg::PROD_W'(64'(1) << (VALUE_BITS - 1));

  rau_pkg::state_t state_r, state_nxt;

  logic [1:0]         cmd_r;
  logic signed [31:0] ln_r, rn_r, ld_r, rd_r;
  logic [1:0]         mcnt_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic [63:0]        nm_r, dm_r, g_r;
  logic               neg_r, zden_r, less_r, eq_r;
  logic               gcd_go_r, div_go_r;
  logic               out_valid_r;
  rau_pkg::out_t      out_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] n_s, d_s;
  logic [63:0]        gcd_q, div_q, div_n;
  logic               gcd_done, div_done;
  logic               ovf;
  logic [63:0]        neg_nm;
  logic signed [31:0] in_ln, in_rn, tmp_l, tmp_r;

  // Operand taken at the low VALUE_BITS, sign extended.
  always_comb begin
    tmp_l = in_data.lhs_num << SH;
    tmp_r = in_data.rhs_num << SH;
    in_ln = tmp_l >>> SH;
    in_rn = tmp_r >>> SH;
  end

  // Shared 32x32 multiplier operand selection.
  always_comb begin
    case (mcnt_r)
      2'd0:    begin mul_a = ln_r; mul_b = rd_r; end
      2'd1:    begin mul_a = rn_r; mul_b = ld_r; end
      2'd2:    begin mul_a = ln_r; mul_b = rn_r; end
      default: begin mul_a = ld_r; mul_b = rd_r; end
    endcase
    prod = mul_a * mul_b;
  end

  // Raw result numerator and denominator from the products.
  always_comb begin
    case (cmd_r)
      rau_pkg::CMD_ADD: begin n_s = p0_r + p1_r; d_s = p3_r; end
      rau_pkg::CMD_SUB: begin n_s = p0_r - p1_r; d_s = p3_r; end
      rau_pkg::CMD_MUL: begin n_s = p2_r;        d_s = p3_r; end
      default:          begin n_s = p0_r;        d_s = p1_r; end
    endcase
  end

  // Range check of the reduced result.
  always_comb begin
    ovf    = (dm_r > LIM - 64'(1)) || (nm_r > (neg_r ? LIM : LIM - 64'(1)));
    neg_nm = 64'(0) - nm_r;
  end

  assign div_n = (state_r == rau_pkg::S_DIVN) ? nm_r : dm_r;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (gcd_go_r),
    .a_in  (nm_r),
    .b_in  (dm_r),
    .gcd   (gcd_q),
    .done  (gcd_done)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_n),
    .divisor  (g_r),
    .quotient (div_q),
    .done     (div_done)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::S_IDLE:  if (in_valid) state_nxt = rau_pkg::S_MUL;
      rau_pkg::S_MUL:   if (mcnt_r == 2'd3) state_nxt = rau_pkg::S_CALC;
      rau_pkg::S_CALC: begin
        if (d_s == 64'sd0 || n_s == 64'sd0) state_nxt = rau_pkg::S_CHECK;
        else                                 state_nxt = rau_pkg::S_GCD;
      end
      rau_pkg::S_GCD:   if (gcd_done) state_nxt = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN:  if (div_done) state_nxt = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD:  if (div_done) state_nxt = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK: state_nxt = rau_pkg::S_WAIT;
      rau_pkg::S_WAIT:  if (!out_valid_r || !out_stall) state_nxt = rau_pkg::S_IDLE;
      default:          state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      gcd_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      mcnt_r      <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      gcd_go_r <= (state_r == rau_pkg::S_CALC) && (state_nxt == rau_pkg::S_GCD);
      div_go_r <= div_done && (state_r == rau_pkg::S_DIVN) ||
                  gcd_done && (state_r == rau_pkg::S_GCD);
      if (state_r == rau_pkg::S_MUL) mcnt_r <= mcnt_r + 2'd1;
      else                           mcnt_r <= 2'd0;
      if (state_r == rau_pkg::S_WAIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::S_IDLE: begin
        cmd_r <= in_data.cmd;
        ln_r  <= in_ln;
        rn_r  <= in_rn;
        ld_r  <= $signed({1'b0, in_data.lhs_den & DMSK});
        rd_r  <= $signed({1'b0, in_data.rhs_den & DMSK});
      end
      rau_pkg::S_MUL: begin
        case (mcnt_r)
          2'd0:    p0_r <= prod;
          2'd1:    p1_r <= prod;
          2'd2:    p2_r <= prod;
          default: p3_r <= prod;
        endcase
      end
      rau_pkg::S_CALC: begin
        less_r <= (p0_r < p1_r);
        eq_r   <= (ln_r == rn_r) && (ld_r == rd_r);
        zden_r <= (d_s == 64'sd0);
        if (n_s == 64'sd0) begin
          nm_r  <= 64'd0;
          dm_r  <= 64'd1;
          neg_r <= 1'b0;
        end else begin
          nm_r  <= n_s[63] ? 64'(-n_s) : 64'(n_s);
          dm_r  <= d_s[63] ? 64'(-d_s) : 64'(d_s);
          neg_r <= n_s[63] ^ d_s[63];
        end
      end
      rau_pkg::S_GCD:  if (gcd_done) g_r <= gcd_q;
      rau_pkg::S_DIVN: if (div_done) nm_r <= div_q;
      rau_pkg::S_DIVD: if (div_done) dm_r <= div_q;
      // The result register loads only once the previous result has left it.
      rau_pkg::S_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_r.lhs_less       <= less_r;
          out_r.operands_equal <= eq_r;
          if (zden_r) begin
            out_r.status  <= rau_pkg::ST_DIV0;
            out_r.res_num <= '0;
            out_r.res_den <= '0;
          end else if (ovf) begin
            out_r.status  <= rau_pkg::ST_OVF;
            out_r.res_num <= '0;
            out_r.res_den <= '0;
          end else begin
            out_r.status  <= rau_pkg::ST_OK;
            out_r.res_num <= $signed(neg_r ? neg_nm[31:0] : nm_r[31:0]);
            out_r.res_den <= dm_r[30:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != rau_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A new result appears only after the sequencer has left its wait state.
  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rau_pkg::S_WAIT))
    else $error("result raised outside the wait state");

  // Error results carry zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != rau_pkg::ST_OK |->
      out_r.res_num == 32'sd0 && out_r.res_den == 31'd0)
    else $error("error result with nonzero fields");

  // A good result has a nonzero denominator.
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == rau_pkg::ST_OK |-> out_r.res_den != 31'd0)
    else $error("ok result with zero denominator");
`endif

endmodule

FILE: tb/rational_arith_unit_top_tb.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_top_tb: self-checking bench for the rational unit
// Drives a table of directed operand pairs and then random ones through the
// valid/stall input channel. Rows without a fixed expectation and all random
// ones are predicted by a local 64-bit rational reducer; all are compared
// field by field at the output, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module rational_arith_unit_top_tb;

  localparam int DIRECTED_N = 22;
  localparam int RANDOM_N   = 1450;
  localparam int DRAIN_CYC  = 400;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  rau_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall;
  rau_pkg::out_t  out_data;

  rau_pkg::out_t  pending_q[$];
  int             err_cnt;
  bit             stim_done;

  rational_arith_unit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a period of 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reports one mismatch and counts it.
  task automatic report_mismatch(input string what, input rau_pkg::out_t got,
                                 input rau_pkg::out_t want);
    err_cnt++;
    $display("mismatch %s: got %0d/%0d st%0d lt%0d eq%0d, want %0d/%0d st%0d lt%0d eq%0d",
             what, got.res_num, got.res_den, got.status, got.lhs_less,
             got.operands_equal, want.res_num, want.res_den, want.status,
             want.lhs_less, want.operands_equal);
  endtask

  // Euclidean GCD of two magnitudes.
  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 64'd0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Computes the reduced rational and the comparison flags for one transaction.
  function automatic rau_pkg::out_t reduce_rational(input rau_pkg::in_t it);
    longint        ln, ld, rn, rd, n, d;
    logic [63:0]   nm, dm, g;
    logic [63:0]   lim;
    bit            neg;
    rau_pkg::out_t r;
    ln = longint'(it.lhs_num);
    rn = longint'(it.rhs_num);
    ld = longint'({33'd0, it.lhs_den});
    rd = longint'({33'd0, it.rhs_den});
    case (it.cmd)
      rau_pkg::CMD_ADD: begin n = ln * rd + rn * ld; d = ld * rd; end
      rau_pkg::CMD_SUB: begin n = ln * rd - rn * ld; d = ld * rd; end
      rau_pkg::CMD_MUL: begin n = ln * rn;           d = ld * rd; end
      default:          begin n = ln * rd;           d = ld * rn; end
    endcase
    r = '0;
    if (d == 0) begin
      r.status = rau_pkg::ST_DIV0;
    end else begin
      nm  = (n < 0) ? 64'd0 - 64'(n) : 64'(n);
      dm  = (d < 0) ? 64'd0 - 64'(d) : 64'(d);
      neg = (n < 0) != (d < 0);
      g   = gcd64(nm, dm);
      nm  = nm / g;
      dm  = dm / g;
      lim = 64'd1 << 31;
      if (nm == 64'd0) begin
        neg = 1'b0;
        dm  = 64'd1;
      end
      if (dm > lim - 1 || nm > (neg ? lim : lim - 1)) begin
        r.status = rau_pkg::ST_OVF;
      end else begin
        r.status  = rau_pkg::ST_OK;
        r.res_num = neg ? 32'(64'd0 - nm) : nm[31:0];
        r.res_den = dm[30:0];
      end
    end
    r.lhs_less       = (ln * rd < ld * rn);
    r.operands_equal = (ln == rn) && (ld == rd);
    return r;
  endfunction

  // Directed table; a row with fixed set carries a hand-written expectation.
  typedef struct {
    rau_pkg::in_t  stim;
    bit            fixed;
    rau_pkg::out_t want;
  } dir_row_t;

  dir_row_t dir_tbl[DIRECTED_N];

  function automatic rau_pkg::in_t mk(input logic [1:0] c, input int a, input int b,
                                      input int x, input int y);
    rau_pkg::in_t t;
    t.cmd = c; t.lhs_num = a; t.lhs_den = b[30:0];
    t.rhs_num = x; t.rhs_den = y[30:0];
    return t;
  endfunction

  function automatic rau_pkg::out_t mo(input int n, input int d, input logic [1:0] s,
                                       input bit lt, input bit eq);
    rau_pkg::out_t o;
    o.res_num = n; o.res_den = d[30:0]; o.status = s;
    o.lhs_less = lt; o.operands_equal = eq;
    return o;
  endfunction

  initial begin
    dir_tbl[0]  = '{mk(rau_pkg::CMD_ADD, 1, 2, 1, 3), 1, mo(5, 6, rau_pkg::ST_OK, 0, 0)};
    dir_tbl[1]  = '{mk(rau_pkg::CMD_SUB, 1, 2, 1, 2), 1, mo(0, 1, rau_pkg::ST_OK, 0, 1)};
    dir_tbl[2]  = '{mk(rau_pkg::CMD_MUL, 2, 3, 3, 4), 1, mo(1, 2, rau_pkg::ST_OK, 1, 0)};
    dir_tbl[3]  = '{mk(rau_pkg::CMD_DIV, 1, 2, 0, 1), 1, mo(0, 0, rau_pkg::ST_DIV0, 0, 0)};
    dir_tbl[4]  = '{mk(rau_pkg::CMD_ADD, 1, 0, 1, 1), 1, mo(0, 0, rau_pkg::ST_DIV0, 0, 0)};
    dir_tbl[5]  = '{mk(rau_pkg::CMD_MUL, 5, 7, 0, 1), 1, mo(0, 1, rau_pkg::ST_OK, 0, 0)};
    dir_tbl[6]  = '{mk(rau_pkg::CMD_DIV, -3, 4, 3, 4), 1, mo(-1, 1, rau_pkg::ST_OK, 1, 0)};
    dir_tbl[7]  = '{mk(rau_pkg::CMD_DIV, 3, 4, -3, 8), 1, mo(-2, 1, rau_pkg::ST_OK, 0, 0)};
    dir_tbl[8]  = '{mk(rau_pkg::CMD_ADD, 32'h7fffffff, 1, 1, 1), 1,
                    mo(0, 0, rau_pkg::ST_OVF, 0, 0)};
    dir_tbl[9]  = '{mk(rau_pkg::CMD_SUB, 32'h80000000, 1, 1, 1), 1,
                    mo(0, 0, rau_pkg::ST_OVF, 1, 0)};
    dir_tbl[10] = '{mk(rau_pkg::CMD_SUB, 32'h80000001, 1, 1, 1), 1,
                    mo(32'h80000000, 1, rau_pkg::ST_OK, 1, 0)};
    dir_tbl[11] = '{mk(rau_pkg::CMD_MUL, 32'h80000000, 1, 32'h80000000, 1), 1,
                    mo(0, 0, rau_pkg::ST_OVF, 0, 1)};
    dir_tbl[12] = '{mk(rau_pkg::CMD_DIV, 1, 32'h7fffffff, 32'h7fffffff, 1), 0, '0};
    dir_tbl[13] = '{mk(rau_pkg::CMD_MUL, 1, 32'h7fffffff, 1, 32'h7fffffff), 1,
                    mo(0, 0, rau_pkg::ST_OVF, 0, 1)};
    dir_tbl[14] = '{mk(rau_pkg::CMD_ADD, 4, 6, 2, 6), 1, mo(1, 1, rau_pkg::ST_OK, 0, 0)};
    dir_tbl[15] = '{mk(rau_pkg::CMD_DIV, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff), 0, '0};
    dir_tbl[16] = '{mk(rau_pkg::CMD_SUB, -1, 32'h7ffffffe, 1, 32'h7fffffff), 0, '0};
    dir_tbl[17] = '{mk(rau_pkg::CMD_ADD, 0, 0, 0, 0), 1, mo(0, 0, rau_pkg::ST_DIV0, 0, 1)};
    dir_tbl[18] = '{mk(rau_pkg::CMD_DIV, 32'h80000000, 1, -1, 1), 1,
                    mo(0, 0, rau_pkg::ST_OVF, 1, 0)};
    dir_tbl[19] = '{mk(rau_pkg::CMD_MUL, -7, 3, -3, 7), 1, mo(1, 1, rau_pkg::ST_OK, 1, 0)};
    dir_tbl[20] = '{mk(rau_pkg::CMD_ADD, 32'h55555555, 32'h2aaaaaaa, 32'haaaaaaaa,
                       32'h55555555), 0, '0};
    dir_tbl[21] = '{mk(rau_pkg::CMD_SUB, 1, 3, 2, 5), 0, '0};
  end

  // Random operand; mostly small values so that results stay in range.
  function automatic rau_pkg::in_t rand_item();
    rau_pkg::in_t t;
    int           k;
    t.cmd = 2'($urandom_range(3));
    k = $urandom_range(9);
    if (k < 4) begin
      t.lhs_num = $signed($urandom_range(200)) - 100;
      t.rhs_num = $signed($urandom_range(200)) - 100;
      t.lhs_den = 31'($urandom_range(60, 1));
      t.rhs_den = 31'($urandom_range(60, 1));
    end else if (k < 7) begin
      t.lhs_num = $signed($urandom_range(131070)) - 65535;
      t.rhs_num = $signed($urandom_range(131070)) - 65535;
      t.lhs_den = 31'($urandom_range(65535, 1));
      t.rhs_den = 31'($urandom_range(65535, 1));
    end else begin
      t.lhs_num = $urandom;
      t.rhs_num = $urandom;
      t.lhs_den = 31'($urandom);
      t.rhs_den = 31'($urandom);
      if ($urandom_range(15) == 0) t.rhs_num = 0;
    end
    if ($urandom_range(7) == 0) begin
      t.rhs_num = t.lhs_num;
      t.rhs_den = t.lhs_den;
    end
    return t;
  endfunction

  // Sends one transaction after a random gap and records its expectation.
  task automatic send_item(input rau_pkg::in_t it, input bit fixed,
                           input rau_pkg::out_t want);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(fixed ? want : reduce_rational(it));
  endtask

  // Stimulus: reset, directed table, then random traffic.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    err_cnt   = 0;
    stim_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_item(dir_tbl[i].stim, dir_tbl[i].fixed, dir_tbl[i].want);
    end
    for (int i = 0; i < RANDOM_N; i++) begin
      // Let the block drain completely once, halfway through the random items.
      if (i == RANDOM_N / 2) begin
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      send_item(rand_item(), 1'b0, '0);
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // Output side: random stall per transaction, compare on acceptance.
  initial begin
    int            hold;
    rau_pkg::out_t want;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected", out_data, '0);
      end else begin
        want = pending_q.pop_front();
        if (out_data.res_num !== want.res_num) report_mismatch("res_num", out_data, want);
        if (out_data.res_den !== want.res_den) report_mismatch("res_den", out_data, want);
        if (out_data.status !== want.status) report_mismatch("status", out_data, want);
        if (out_data.lhs_less !== want.lhs_less)
          report_mismatch("lhs_less", out_data, want);
        if (out_data.operands_equal !== want.operands_equal)
          report_mismatch("operands_equal", out_data, want);
      end
    end
  end

  // End of run once everything has drained.
  initial begin
    @(posedge rst_n);
    while (!(stim_done && pending_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #60000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
